### sv/swept_circle_time_of_impact_defines.svh
// Assertion macros for the swept circle time of impact block.
`ifndef SWEPT_CIRCLE_TIME_OF_IMPACT_DEFINES_SVH
`define SWEPT_CIRCLE_TIME_OF_IMPACT_DEFINES_SVH
// Asserts that an implication holds at every clock edge outside reset.
`define SCT_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Asserts that an implication holds in the cycle after the antecedent.
`define SCT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

### sv/sct_pkg.sv
// Package with shared types and constants for the swept circle time of impact block.
package sct_pkg;
    localparam int FRAC_BITS_DEFAULT = 16;
    localparam int DISC_W = 130;
    localparam int ROOT_W = 64 + 24;
    typedef enum logic [1:0] {
        HIT_OVERLAP = 2'd0,
        HIT_NONE    = 2'd1,
        HIT_TIME    = 2'd2
    } hit_status_t;
endpackage

### sv/sct_isqrt.sv
// Pipelined floor square root, one result bit per stage.
module sct_isqrt #(
    parameter int IN_W  = 160,
    parameter int OUT_W = 80,
    parameter int TAG_W = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [IN_W-1:0]  in_value,
    input  logic [TAG_W-1:0] in_tag,
    output logic             out_valid,
    output logic [OUT_W-1:0] out_root,
    output logic [TAG_W-1:0] out_tag
);
    localparam int RW = 2 * OUT_W + 2;
    logic [RW-1:0]    rem_reg  [OUT_W+1];
    logic [OUT_W-1:0] root_reg [OUT_W+1];
    logic [IN_W-1:0]  val_reg  [OUT_W+1];
    logic [TAG_W-1:0] tag_reg  [OUT_W+1];
    logic             vld_reg  [OUT_W+1];

    always_comb begin
        rem_reg[0]  = '0;
        root_reg[0] = '0;
        val_reg[0]  = in_value;
        tag_reg[0]  = in_tag;
        vld_reg[0]  = in_valid;
    end

    for (genvar k = 0; k < OUT_W; k++) begin : g_stage
        localparam int B = OUT_W - 1 - k;
        logic [RW-1:0] rem_next;
        logic [RW-1:0] trial;
        always_comb begin
            rem_next = {rem_reg[k][RW-3:0], val_reg[k][2*B+1], val_reg[k][2*B]};
            trial = {root_reg[k], 2'b01};
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k+1] <= 1'b0;
            end else if (en) begin
                vld_reg[k+1] <= vld_reg[k];
            end
            if (en) begin
                val_reg[k+1] <= val_reg[k];
                tag_reg[k+1] <= tag_reg[k];
                if (rem_next >= trial) begin
                    rem_reg[k+1]  <= rem_next - trial;
                    root_reg[k+1] <= {root_reg[k][OUT_W-2:0], 1'b1};
                end else begin
                    rem_reg[k+1]  <= rem_next;
                    root_reg[k+1] <= {root_reg[k][OUT_W-2:0], 1'b0};
                end
            end
        end
    end

    assign out_valid = vld_reg[OUT_W];
    assign out_root  = root_reg[OUT_W];
    assign out_tag   = tag_reg[OUT_W];
endmodule

### sv/sct_divide.sv
// Pipelined restoring divider, one quotient bit per stage.
module sct_divide #(
    parameter int N_W   = 100,
    parameter int D_W   = 66,
    parameter int TAG_W = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [N_W-1:0]   in_num,
    input  logic [D_W-1:0]   in_den,
    input  logic [TAG_W-1:0] in_tag,
    output logic             out_valid,
    output logic [N_W-1:0]   out_quot,
    output logic [TAG_W-1:0] out_tag
);
    localparam int RW = D_W + 1;
    logic [RW-1:0]    rem_reg [N_W+1];
    logic [N_W-1:0]   num_reg [N_W+1];
    logic [N_W-1:0]   q_reg   [N_W+1];
    logic [D_W-1:0]   den_reg [N_W+1];
    logic [TAG_W-1:0] tag_reg [N_W+1];
    logic             vld_reg [N_W+1];

    always_comb begin
        rem_reg[0] = '0;
        num_reg[0] = in_num;
        q_reg[0]   = '0;
        den_reg[0] = in_den;
        tag_reg[0] = in_tag;
        vld_reg[0] = in_valid;
    end

    for (genvar k = 0; k < N_W; k++) begin : g_stage
        localparam int B = N_W - 1 - k;
        logic [RW-1:0] sh;
        always_comb sh = {rem_reg[k][RW-2:0], num_reg[k][B]};
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k+1] <= 1'b0;
            end else if (en) begin
                vld_reg[k+1] <= vld_reg[k];
            end
            if (en) begin
                num_reg[k+1] <= num_reg[k];
                den_reg[k+1] <= den_reg[k];
                tag_reg[k+1] <= tag_reg[k];
                if (sh >= {1'b0, den_reg[k]}) begin
                    rem_reg[k+1] <= sh - {1'b0, den_reg[k]};
                    q_reg[k+1]   <= q_reg[k] | (N_W'(1) << B);
                end else begin
                    rem_reg[k+1] <= sh;
                    q_reg[k+1]   <= q_reg[k];
                end
            end
        end
    end

    assign out_valid = vld_reg[N_W];
    assign out_quot  = q_reg[N_W];
    assign out_tag   = tag_reg[N_W];
endmodule

### sv/swept_circle_time_of_impact.sv
// Top level of the swept circle time of impact pipeline.
// Throughput: one transaction per cycle while the output is not stalled; every stage
// is registered and the whole pipe advances together, so the square root and divider
// pipelines set the depth. A stall on the output holds every stage; s_tready follows
// m_tready or an empty output. Reset (aresetn low, synchronous) clears all valid bits;
// data registers are not reset.
`include "swept_circle_time_of_impact_defines.svh"
module swept_circle_time_of_impact #(
    parameter int FRAC_BITS = sct_pkg::FRAC_BITS_DEFAULT
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // first_x, first_y, second_x, second_y, first_radius, second_radius,
    // first_vel_x, first_vel_y, second_vel_x, second_vel_y (from bit 0 up)
    input  logic [319:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // hit_status, impact_time (from bit 0 up)
    output logic [39:0]  m_tdata
);
    localparam int SW = 65 + FRAC_BITS;
    localparam int NW = 67 + FRAC_BITS;
    localparam int TW = 4;

    logic en;
    logic s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg, s5_v_reg, s6_v_reg, s7_v_reg;
    logic out_v_reg;
    assign en = !out_v_reg || m_tready;
    assign s_tready = en;

    logic signed [32:0] dpx_reg, dpy_reg, dvx_reg, dvy_reg;
    logic        [31:0] rs_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) s1_v_reg <= 1'b0;
        else if (en) s1_v_reg <= s_tvalid;
        if (en) begin
            dpx_reg <= $signed({s_tdata[95], s_tdata[95:64]}) -
                       $signed({s_tdata[31], s_tdata[31:0]});
            dpy_reg <= $signed({s_tdata[127], s_tdata[127:96]}) -
                       $signed({s_tdata[63], s_tdata[63:32]});
            rs_reg  <= {1'b0, s_tdata[158:128]} + {1'b0, s_tdata[189:159]};
            dvx_reg <= $signed({s_tdata[285], s_tdata[285:254]}) -
                       $signed({s_tdata[221], s_tdata[221:190]});
            dvy_reg <= $signed({s_tdata[317], s_tdata[317:286]}) -
                       $signed({s_tdata[253], s_tdata[253:222]});
        end
    end

    // Stage 2: products of the 33-bit differences and of the 32-bit radius sum.
    logic signed [65:0] pxx_reg, pyy_reg, vxx_reg, vyy_reg, hx_reg, hy_reg;
    logic        [63:0] rr_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) s2_v_reg <= 1'b0;
        else if (en) s2_v_reg <= s1_v_reg;
        if (en) begin
            pxx_reg <= dpx_reg * dpx_reg;
            pyy_reg <= dpy_reg * dpy_reg;
            vxx_reg <= dvx_reg * dvx_reg;
            vyy_reg <= dvy_reg * dvy_reg;
            hx_reg  <= dpx_reg * dvx_reg;
            hy_reg  <= dpy_reg * dvy_reg;
            rr_reg  <= rs_reg * rs_reg;
        end
    end

    // Stage 3: sums.
    logic        [66:0] dd_reg, a_reg;
    logic signed [66:0] h_reg;
    logic        [63:0] rr3_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) s3_v_reg <= 1'b0;
        else if (en) s3_v_reg <= s2_v_reg;
        if (en) begin
            dd_reg  <= 67'(pxx_reg[65:0]) + 67'(pyy_reg[65:0]);
            a_reg   <= 67'(vxx_reg[65:0]) + 67'(vyy_reg[65:0]);
            h_reg   <= 67'(hx_reg) + 67'(hy_reg);
            rr3_reg <= rr_reg;
        end
    end

    // Stage 4: overlap test, c, |h|.
    logic [66:0] c_reg, a4_reg, hm_reg;
    logic        ov4_reg, hneg4_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) s4_v_reg <= 1'b0;
        else if (en) s4_v_reg <= s3_v_reg;
        if (en) begin
            ov4_reg   <= dd_reg <= 67'(rr3_reg);
            c_reg     <= dd_reg - 67'(rr3_reg);
            a4_reg    <= a_reg;
            hneg4_reg <= h_reg[66];
            hm_reg    <= h_reg[66] ? 67'(-h_reg) : 67'(h_reg);
        end
    end

    // Stage 5: h*h and a*c partial products of the 34-bit low and 33-bit high halves.
    logic [67:0]  hll_reg, hlh_reg, hhh_reg;
    logic [67:0]  acll_reg, aclh_reg, achl_reg, achh_reg;
    logic [66:0]  a5_reg, hm5_reg;
    logic         ov5_reg, hneg5_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) s5_v_reg <= 1'b0;
        else if (en) s5_v_reg <= s4_v_reg;
        if (en) begin
            hll_reg   <= 68'({1'b0, hm_reg[33:0]}) * 68'({1'b0, hm_reg[33:0]});
            hlh_reg   <= 68'({1'b0, hm_reg[33:0]}) * 68'(hm_reg[66:34]);
            hhh_reg   <= 68'(hm_reg[66:34]) * 68'(hm_reg[66:34]);
            acll_reg  <= 68'({1'b0, a4_reg[33:0]}) * 68'({1'b0, c_reg[33:0]});
            aclh_reg  <= 68'({1'b0, a4_reg[33:0]}) * 68'(c_reg[66:34]);
            achl_reg  <= 68'(a4_reg[66:34]) * 68'({1'b0, c_reg[33:0]});
            achh_reg  <= 68'(a4_reg[66:34]) * 68'(c_reg[66:34]);
            a5_reg    <= a4_reg;
            hm5_reg   <= hm_reg;
            ov5_reg   <= ov4_reg;
            hneg5_reg <= hneg4_reg;
        end
    end

    // Stage 6: assemble h*h and a*c.
    logic [133:0] h26_reg, ac_reg;
    logic [66:0]  a6_reg, hm6_reg;
    logic         ov6_reg, hneg6_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) s6_v_reg <= 1'b0;
        else if (en) s6_v_reg <= s5_v_reg;
        if (en) begin
            ac_reg    <= 134'(acll_reg) + (134'(aclh_reg) << 34) + (134'(achl_reg) << 34)
                       + (134'(achh_reg) << 68);
            h26_reg   <= 134'(hll_reg) + (134'(hlh_reg) << 35) + (134'(hhh_reg) << 68);
            a6_reg    <= a5_reg;
            hm6_reg   <= hm5_reg;
            ov6_reg   <= ov5_reg;
            hneg6_reg <= hneg5_reg;
        end
    end

    // Stage 7: discriminant and status.
    logic [133:0] disc_reg;
    logic [66:0]  a7_reg, hm7_reg;
    logic         hneg7_reg;
    logic [1:0]   st7_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) s7_v_reg <= 1'b0;
        else if (en) s7_v_reg <= s6_v_reg;
        if (en) begin
            disc_reg  <= h26_reg - ac_reg;
            a7_reg    <= a6_reg;
            hm7_reg   <= hm6_reg;
            hneg7_reg <= hneg6_reg;
            if (ov6_reg) st7_reg <= sct_pkg::HIT_OVERLAP;
            else if (a6_reg == '0 || h26_reg < ac_reg) st7_reg <= sct_pkg::HIT_NONE;
            else st7_reg <= sct_pkg::HIT_TIME;
        end
    end

    // Side data travels beside the root pipeline in a shift line of its own.
    localparam int SIDE_W = 67 + 67 + 1;
    logic [SIDE_W-1:0] side_reg [SW];
    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= {a7_reg, hm7_reg, hneg7_reg};
            for (int k = 1; k < SW; k++) side_reg[k] <= side_reg[k-1];
        end
    end

    logic [2*SW-1:0] rin;
    assign rin = (2*SW)'({disc_reg, {(2*FRAC_BITS){1'b0}}});
    logic          r_v;
    logic [SW-1:0] r_s;
    logic [TW-1:0] r_tag;
    sct_isqrt #(.IN_W(2*SW), .OUT_W(SW), .TAG_W(TW)) u_isqrt (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(s7_v_reg), .in_value(rin), .in_tag({2'b00, st7_reg}),
        .out_valid(r_v), .out_root(r_s), .out_tag(r_tag)
    );

    logic [66:0] ra, rh;
    logic        rneg;
    assign {ra, rh, rneg} = side_reg[SW-1];

    // Stage 8: numerator.
    logic [NW-1:0] num_reg;
    logic [66:0]   a8_reg;
    logic [TW-1:0] tag8_reg;
    logic          v8_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v8_reg <= 1'b0;
        else if (en) v8_reg <= r_v;
        if (en) begin
            a8_reg   <= ra;
            tag8_reg <= {1'b0, !rneg, r_tag[1:0]};
            if (!rneg) num_reg <= (NW'(rh) << FRAC_BITS) + NW'(r_s) + NW'(ra) - NW'(1);
            else       num_reg <= (NW'(rh) << FRAC_BITS) - NW'(r_s);
        end
    end

    logic          d_v;
    logic [NW-1:0] d_q;
    logic [TW-1:0] d_tag;
    sct_divide #(.N_W(NW), .D_W(67), .TAG_W(TW)) u_div (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(v8_reg), .in_num(num_reg),
        .in_den((a8_reg == '0) ? 67'd1 : a8_reg), .in_tag(tag8_reg),
        .out_valid(d_v), .out_quot(d_q), .out_tag(d_tag)
    );

    logic [1:0]  out_st_reg;
    logic [31:0] out_t_reg;
    logic [31:0] t_next;
    always_comb begin
        if (d_tag[1:0] != sct_pkg::HIT_TIME) t_next = '0;
        else if (d_tag[2]) t_next = (d_q > NW'(32'h8000_0000)) ? 32'h8000_0000
                                                               : 32'(-d_q);
        else t_next = (d_q > NW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : d_q[31:0];
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) out_v_reg <= 1'b0;
        else if (en) out_v_reg <= d_v;
        if (en) begin
            out_st_reg <= d_tag[1:0];
            out_t_reg  <= t_next;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {6'd0, out_t_reg, out_st_reg};

    `SCT_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled output changed")
    `SCT_ASSERT_IMP(a_code, aclk, aresetn, m_tvalid, out_st_reg != 2'd3, "bad status")
    `SCT_ASSERT_IMP(a_zero, aclk, aresetn, m_tvalid && out_st_reg != sct_pkg::HIT_TIME, out_t_reg == '0, "time not zero")
endmodule
